// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)

`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== hdl/dmwbc_pkg.sv =====
`default_nettype none

package dmwbc_pkg;

  localparam int LINES          = 16;
  localparam int WORDS_PER_LINE = 2;
  localparam int WORD_BITS      = 32;
  localparam int MEM_WORDS      = 65536;

  localparam int ADDR_W    = 16;
  localparam int OFF_W     = $clog2(WORDS_PER_LINE);
  localparam int LINE_W    = $clog2(LINES);
  localparam int TAG_W     = ADDR_W - LINE_W - OFF_W;
  localparam int SLOT_W    = LINE_W + OFF_W;
  localparam int SLOTS     = LINES * WORDS_PER_LINE;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int COST_W    = 16;
  localparam int ACC_W     = 18;
  localparam int TIME_W    = 32;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] RST_MEM_READ_COST    = COST_W'(100);
  localparam logic [COST_W-1:0] RST_MEM_WRITE_COST   = COST_W'(50);
  localparam logic [COST_W-1:0] RST_CACHE_READ_COST  = COST_W'(1);
  localparam logic [COST_W-1:0] RST_CACHE_WRITE_COST = COST_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 0,
    OP_WRITE = 1,
    OP_CLEAR = 2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_READ_COST    = 0,
    CFG_MEM_WRITE_COST   = 1,
    CFG_CACHE_READ_COST  = 2,
    CFG_CACHE_WRITE_COST = 3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB_RD,
    ST_WB_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_ACCESS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic lookup;
    logic wb_rd;
    logic wb_wr;
    logic fill_rd;
    logic fill_wr;
    logic acc_rd;
    logic acc_wr;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_rw;
    logic op_read;
    logic hit;
    logic victim_dirty;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/dmwbc_in_if.sv =====
`default_nettype none

interface dmwbc_in_if import dmwbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [ADDR_W-1:0]    word_addr;
  logic [WORD_BITS-1:0] write_word;

  modport source (output valid, output op, output word_addr, output write_word, input ready);
  modport sink   (input valid, input op, input word_addr, input write_word, output ready);
endinterface

`default_nettype wire

// ===== hdl/dmwbc_out_if.sv =====
`default_nettype none

interface dmwbc_out_if import dmwbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] read_word;
  logic                 hit;
  logic                 wrote_back;
  logic [ACC_W-1:0]     access_cost;
  logic [TIME_W-1:0]    elapsed_time;

  modport source (output valid, output read_word, output hit, output wrote_back,
                  output access_cost, output elapsed_time, input ready);
  modport sink   (input valid, input read_word, input hit, input wrote_back,
                  input access_cost, input elapsed_time, output ready);
endinterface

`default_nettype wire

// ===== hdl/dmwbc_ctrl.sv =====
`default_nettype none

module dmwbc_ctrl import dmwbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!status.op_rw) begin
          state_nxt = ST_FINISH;
        end else if (status.hit) begin
          state_nxt = ST_ACCESS;
        end else if (status.victim_dirty) begin
          state_nxt = ST_WB_RD;
        end else begin
          state_nxt = ST_FILL_RD;
        end
      end
      ST_WB_RD:   state_nxt = ST_WB_WR;
      ST_WB_WR:   state_nxt = status.cnt_last ? ST_FILL_RD : ST_WB_RD;
      ST_FILL_RD: state_nxt = ST_FILL_WR;
      ST_FILL_WR: state_nxt = status.cnt_last ? ST_ACCESS : ST_FILL_RD;
      ST_ACCESS:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR:   cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOKUP:  cmd.lookup  = 1'b1;
      ST_WB_RD:   cmd.wb_rd   = 1'b1;
      ST_WB_WR:   cmd.wb_wr   = 1'b1;
      ST_FILL_RD: cmd.fill_rd = 1'b1;
      ST_FILL_WR: cmd.fill_wr = 1'b1;
      ST_ACCESS: begin
        cmd.acc_rd = status.op_read;
        cmd.acc_wr = !status.op_read;
      end
      ST_FINISH:  cmd.finish  = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dmwbc_datapath.sv =====
`default_nettype none

module dmwbc_datapath import dmwbc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [COST_W-1:0]    cfg_wdata,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic [ADDR_W-1:0]    in_word_addr,
  input  wire logic [WORD_BITS-1:0] in_write_word,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [WORD_BITS-1:0]      out_read_word,
  output logic                      out_hit,
  output logic                      out_wrote_back,
  output logic [ACC_W-1:0]          out_access_cost,
  output logic [TIME_W-1:0]         out_elapsed_time
);

  logic [COST_W-1:0] mem_read_cost_r;
  logic [COST_W-1:0] mem_write_cost_r;
  logic [COST_W-1:0] cache_read_cost_r;
  logic [COST_W-1:0] cache_write_cost_r;

  logic [OP_W-1:0]      op_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [WORD_BITS-1:0] wdata_r;

  logic [LINES-1:0]  valid_r;
  logic [LINES-1:0]  dirty_r;
  logic [TAG_W-1:0]  tag_r [LINES];

  logic [MEM_AW-1:0] clr_addr_r;
  logic [MEM_AW-1:0] clr_addr_nxt;
  logic [OFF_W-1:0]  cnt_r;
  logic [OFF_W-1:0]  cnt_nxt;
  logic              hit_r;
  logic              wb_r;
  logic [ACC_W-1:0]  acc_cost_r;
  logic [ACC_W-1:0]  acc_cost_nxt;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] time_nxt;
  logic [TIME_W-1:0] elapsed_sum;

  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_read_word_r;
  logic                 out_hit_r;
  logic                 out_wrote_back_r;
  logic [ACC_W-1:0]     out_access_cost_r;
  logic [TIME_W-1:0]    out_elapsed_time_r;

  logic [WORD_BITS-1:0] line_mem [SLOTS];
  logic [WORD_BITS-1:0] back_mem [MEM_WORDS];
  logic [WORD_BITS-1:0] line_rdata_r;
  logic [WORD_BITS-1:0] mem_rdata_r;

  logic [LINE_W-1:0]    line;
  logic [OFF_W-1:0]     off;
  logic [TAG_W-1:0]     tag;
  logic                 lookup_hit;
  logic                 victim_dirty;
  logic                 cnt_last;
  logic                 cnt_step;
  logic [SLOT_W-1:0]    line_waddr;
  logic [SLOT_W-1:0]    line_raddr;
  logic [WORD_BITS-1:0] line_wdata;
  logic                 line_we;
  logic                 line_re;
  logic [ADDR_W-1:0]    victim_addr;
  logic [ADDR_W-1:0]    fill_addr;
  logic [MEM_AW-1:0]    mem_waddr;
  logic [MEM_AW-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_we;

  // address split and tag check
  assign line         = addr_r[OFF_W +: LINE_W];
  assign off          = addr_r[OFF_W-1:0];
  assign tag          = addr_r[ADDR_W-1 -: TAG_W];
  assign lookup_hit   = valid_r[line] && (tag_r[line] == tag);
  assign victim_dirty = valid_r[line] && dirty_r[line];
  assign cnt_last     = (cnt_r == OFF_W'(WORDS_PER_LINE - 1));
  assign cnt_step     = cmd.wb_wr || cmd.fill_wr;

  assign status.clr_last     = (clr_addr_r == MEM_AW'(MEM_WORDS - 1));
  assign status.op_rw        = (op_r == OP_READ) || (op_r == OP_WRITE);
  assign status.op_read      = (op_r == OP_READ);
  assign status.hit          = lookup_hit;
  assign status.victim_dirty = victim_dirty;
  assign status.cnt_last     = cnt_last;
  assign status.out_free     = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_read_cost_r    <= RST_MEM_READ_COST;
      mem_write_cost_r   <= RST_MEM_WRITE_COST;
      cache_read_cost_r  <= RST_CACHE_READ_COST;
      cache_write_cost_r <= RST_CACHE_WRITE_COST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MEM_READ_COST:    mem_read_cost_r    <= cfg_wdata;
        CFG_MEM_WRITE_COST:   mem_write_cost_r   <= cfg_wdata;
        CFG_CACHE_READ_COST:  cache_read_cost_r  <= cfg_wdata;
        CFG_CACHE_WRITE_COST: cache_write_cost_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      addr_r  <= in_word_addr;
      wdata_r <= in_write_word;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (cmd.fill_wr && cnt_last) begin
        valid_r[line] <= 1'b1;
        dirty_r[line] <= 1'b0;
      end
      if (cmd.acc_wr) dirty_r[line] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr && cnt_last) tag_r[line] <= tag;
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (cmd.clr_wr) clr_addr_nxt = clr_addr_r + MEM_AW'(1);

    cnt_nxt = cnt_r;
    if (cmd.lookup || (cnt_step && cnt_last)) begin
      cnt_nxt = '0;
    end else if (cnt_step) begin
      cnt_nxt = cnt_r + OFF_W'(1);
    end

    acc_cost_nxt = acc_cost_r;
    if (cmd.lookup) begin
      acc_cost_nxt = (lookup_hit ? '0 : ACC_W'(mem_read_cost_r))
                   + ((!lookup_hit && victim_dirty) ? ACC_W'(mem_write_cost_r) : '0);
    end else if (cmd.acc_rd) begin
      acc_cost_nxt = acc_cost_r + ACC_W'(cache_read_cost_r);
    end else if (cmd.acc_wr) begin
      acc_cost_nxt = acc_cost_r + ACC_W'(cache_write_cost_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      cnt_r      <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_cost_r <= acc_cost_nxt;
    if (cmd.lookup) begin
      hit_r <= lookup_hit;
      wb_r  <= !lookup_hit && victim_dirty;
    end
  end

  // cache line storage
  assign line_we    = cmd.fill_wr || cmd.acc_wr;
  assign line_re    = cmd.wb_rd || cmd.acc_rd;
  assign line_waddr = cmd.fill_wr ? {line, cnt_r} : {line, off};
  assign line_raddr = cmd.wb_rd ? {line, cnt_r} : {line, off};
  assign line_wdata = cmd.fill_wr ? mem_rdata_r : wdata_r;

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_waddr] <= line_wdata;
    if (line_re) line_rdata_r <= line_mem[line_raddr];
  end

  // backing memory, swept to zero after reset
  assign victim_addr = {tag_r[line], line, cnt_r};
  assign fill_addr   = {tag, line, cnt_r};
  assign mem_we      = cmd.clr_wr || cmd.wb_wr;
  assign mem_waddr   = cmd.clr_wr ? clr_addr_r : victim_addr[MEM_AW-1:0];
  assign mem_wdata   = cmd.clr_wr ? '0 : line_rdata_r;
  assign mem_raddr   = fill_addr[MEM_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) back_mem[mem_waddr] <= mem_wdata;
    if (cmd.fill_rd) mem_rdata_r <= back_mem[mem_raddr];
  end

  // elapsed time and result register
  assign elapsed_sum = time_r + TIME_W'(acc_cost_r);

  always_comb begin
    time_nxt = time_r;
    if (cmd.finish) begin
      case (op_r)
        OP_READ, OP_WRITE: time_nxt = elapsed_sum;
        OP_CLEAR:          time_nxt = '0;
        default:           time_nxt = time_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      time_r <= time_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (op_r)
        OP_READ, OP_WRITE: begin
          out_read_word_r    <= (op_r == OP_READ) ? line_rdata_r : '0;
          out_hit_r          <= hit_r;
          out_wrote_back_r   <= wb_r;
          out_access_cost_r  <= acc_cost_r;
          out_elapsed_time_r <= elapsed_sum;
        end
        OP_CLEAR: begin
          out_read_word_r    <= '0;
          out_hit_r          <= 1'b0;
          out_wrote_back_r   <= 1'b0;
          out_access_cost_r  <= '0;
          out_elapsed_time_r <= '0;
        end
        default: begin
          out_read_word_r    <= '0;
          out_hit_r          <= 1'b0;
          out_wrote_back_r   <= 1'b0;
          out_access_cost_r  <= '0;
          out_elapsed_time_r <= time_r;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_word    = out_read_word_r;
  assign out_hit          = out_hit_r;
  assign out_wrote_back   = out_wrote_back_r;
  assign out_access_cost  = out_access_cost_r;
  assign out_elapsed_time = out_elapsed_time_r;

endmodule

`default_nettype wire

// ===== hdl/direct_mapped_write_back_cache_core.sv =====
// channel   dir  handshake                  payload
// in_chan   in   valid/ready                op, word_addr, write_word
// out_chan  out  valid/ready                read_word, hit, wrote_back, access_cost,
//                                           elapsed_time
// cfg_*     in   cfg_we, no back-pressure   cfg_idx, cfg_wdata
//
// one request at a time: a clear or an unused op steps idle, lookup, finish; a hit adds
// an access state; a clean miss fills the line first, a dirty miss writes the victim back
// before the fill; each word moved takes a read state and then a write state
// after reset the backing memory, all 65536 words, is swept to zero with in_ready low
// the result register lets the next request in while a result waits; that request
// then holds in its finish state until the waiting result is taken

`default_nettype none
`include "assert_macros.svh"

module direct_mapped_write_back_cache_core import dmwbc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  dmwbc_in_if.sink                  in_chan,
  dmwbc_out_if.source               out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [COST_W-1:0]    cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dmwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dmwbc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_op            (in_chan.op),
    .in_word_addr     (in_chan.word_addr),
    .in_write_word    (in_chan.write_word),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_read_word    (out_chan.read_word),
    .out_hit          (out_chan.hit),
    .out_wrote_back   (out_chan.wrote_back),
    .out_access_cost  (out_chan.access_cost),
    .out_elapsed_time (out_chan.elapsed_time)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)
  `ASSERT_NEXT(a_finish_loads_result, clk, rst_n, cmd.finish, out_chan.valid)
  `ASSERT_IMPLIES(a_writeback_only_on_miss, clk, rst_n, out_chan.valid && out_chan.wrote_back, !out_chan.hit)

endmodule

`default_nettype wire
